FILE: sv/wplbw_pkg.sv
// Shared constants and types for the warp point blend and bilinear weight block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wplbw_pkg;

    localparam int SCREEN_BITS   = 12;
    localparam int FRACTION_BITS = 4;
    localparam int COORD_W       = 16;
    localparam int FACTOR_W      = 16;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = DIFF_W + FACTOR_W + 1;
    localparam int SHIFT_W       = PROD_W - FACTOR_W;
    localparam int SUM_W         = SHIFT_W + 1;
    localparam int EXT_W         = (FRACTION_BITS + SCREEN_BITS > SUM_W) ?
                                   (FRACTION_BITS + SCREEN_BITS) : SUM_W;
    localparam int WEIGHT_W      = 8;
    localparam int ONE_W         = FRACTION_BITS + 1;
    localparam int WPROD_W       = 2 * ONE_W;

    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // Register index, taken from the word address.
    localparam logic REG_BLEND_FACTOR = 1'b0;

    // Clock enables for the three blend stages and the output stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage
`default_nettype wire

FILE: sv/wplbw_apb.sv
// APB-style configuration port holding the blend factor register.
// Depends on wplbw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wplbw_apb (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wplbw_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [wplbw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [wplbw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready,
    output logic      [wplbw_pkg::FACTOR_W-1:0]     blend_factor
);

    logic [wplbw_pkg::FACTOR_W-1:0] factor_reg;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite &&
                    (paddr[wplbw_pkg::APB_ADDR_W-1] == wplbw_pkg::REG_BLEND_FACTOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= '0;
        end
        else if (wr_en)
        begin
            factor_reg <= pwdata[wplbw_pkg::FACTOR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[wplbw_pkg::APB_ADDR_W-1] == wplbw_pkg::REG_BLEND_FACTOR)
        begin
            prdata[wplbw_pkg::FACTOR_W-1:0] = factor_reg;
        end
    end

    assign blend_factor = factor_reg;

endmodule
`default_nettype wire

FILE: sv/wplbw_blend.sv
// Three-stage blend of one axis: difference, scaled product, floor shift and add.
// Depends on wplbw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wplbw_blend (
    input  wire logic                                 clk,
    input  wire wplbw_pkg::stage_en_t                 en,
    input  wire logic        [wplbw_pkg::FACTOR_W-1:0] blend_factor,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  src,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  dst,
    output logic signed      [wplbw_pkg::SUM_W-1:0]    blended
);

    logic signed [wplbw_pkg::COORD_W-1:0] src1_reg, src2_reg;
    logic signed [wplbw_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [wplbw_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [wplbw_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic signed [wplbw_pkg::FACTOR_W:0]  factor_s;

    assign diff_next = wplbw_pkg::DIFF_W'(dst) - wplbw_pkg::DIFF_W'(src);
    assign factor_s  = $signed({1'b0, blend_factor});
    assign prod_next = wplbw_pkg::PROD_W'(factor_s) * wplbw_pkg::PROD_W'(diff_reg);
    // An arithmetic shift of the product rounds toward minus infinity.
    assign sum_next  = wplbw_pkg::SUM_W'(src2_reg) +
                       wplbw_pkg::SUM_W'($signed(
                           prod_reg[wplbw_pkg::PROD_W-1:wplbw_pkg::FACTOR_W]));

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            src1_reg <= src;
            diff_reg <= diff_next;
        end
        if (en.s2)
        begin
            src2_reg <= src1_reg;
            prod_reg <= prod_next;
        end
        if (en.s3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign blended = sum_reg;

endmodule
`default_nettype wire

FILE: sv/wplbw_split.sv
// Output stage: splits the blended coordinates into screen position and fraction
// and forms the four bilinear weights. Depends on wplbw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wplbw_split (
    input  wire logic                                  clk,
    input  wire wplbw_pkg::stage_en_t                  en,
    input  wire logic signed [wplbw_pkg::SUM_W-1:0]    bx,
    input  wire logic signed [wplbw_pkg::SUM_W-1:0]    by,
    output logic      [wplbw_pkg::SCREEN_BITS-1:0]     screen_x,
    output logic      [wplbw_pkg::SCREEN_BITS-1:0]     screen_y,
    output logic                                       x_off_screen,
    output logic                                       y_off_screen,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_top_left,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_top_right,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_bottom_left,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_bottom_right
);

    localparam int F  = wplbw_pkg::FRACTION_BITS;
    localparam int S  = wplbw_pkg::SCREEN_BITS;
    localparam int OW = wplbw_pkg::ONE_W;
    localparam int PW = wplbw_pkg::WPROD_W;
    localparam int WW = wplbw_pkg::WEIGHT_W;

    logic signed [wplbw_pkg::EXT_W-1:0] ex, ey;
    logic [OW-1:0] fx, fy, gx, gy;
    logic [PW-1:0] p_tl, p_tr, p_bl, p_br;
    logic [S-1:0]  sx_next, sy_next;
    logic [WW-1:0] tl_next, tr_next, bl_next, br_next;

    logic [S-1:0]  sx_reg, sy_reg;
    logic          xo_reg, yo_reg;
    logic [WW-1:0] tl_reg, tr_reg, bl_reg, br_reg;

    function automatic logic [WW-1:0] dec_nz(input logic [PW-1:0] v);
        logic [PW-1:0] d;
        d = (v != '0) ? (v - PW'(1)) : '0;
        return d[WW-1:0];
    endfunction

    always_comb
    begin
        ex = wplbw_pkg::EXT_W'(bx);
        ey = wplbw_pkg::EXT_W'(by);
        sx_next = ex[F+S-1:F];
        sy_next = ey[F+S-1:F];
        fx = {1'b0, ex[F-1:0]};
        fy = {1'b0, ey[F-1:0]};
        gx = (OW'(1) << F) - fx;
        gy = (OW'(1) << F) - fy;
        p_tl = PW'(gx) * PW'(gy);
        p_tr = PW'(fx) * PW'(gy);
        p_bl = PW'(gx) * PW'(fy);
        p_br = PW'(fx) * PW'(fy);
        tl_next = dec_nz(p_tl);
        tr_next = dec_nz(p_tr);
        bl_next = dec_nz(p_bl);
        br_next = dec_nz(p_br);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            xo_reg <= bx[wplbw_pkg::SUM_W-1];
            yo_reg <= by[wplbw_pkg::SUM_W-1];
            tl_reg <= tl_next;
            tr_reg <= tr_next;
            bl_reg <= bl_next;
            br_reg <= br_next;
        end
    end

    assign screen_x            = sx_reg;
    assign screen_y            = sy_reg;
    assign x_off_screen        = xo_reg;
    assign y_off_screen        = yo_reg;
    assign weight_top_left     = tl_reg;
    assign weight_top_right    = tr_reg;
    assign weight_bottom_left  = bl_reg;
    assign weight_bottom_right = br_reg;

endmodule
`default_nettype wire

FILE: sv/warp_point_lerp_bilinear_weights.sv
// Top level of the warp point blend and bilinear weight block.
// Depends on wplbw_pkg, wplbw_apb, wplbw_blend and wplbw_split.
`timescale 1ns / 1ps
`default_nettype none
// This block takes one item per clock whenever the output side does not stall
// and returns one result per item. It holds four register stages: the
// coordinate difference, the 17 by 17 bit blend product, the floor shift and
// add, and the output stage that forms the screen position, the off-screen
// flags and the four weights. Every stage holds a valid bit, and a stage
// advances whenever it is empty or the stage after it advances, so a stall on
// the output holds every item in place and a bubble is squeezed out as items
// arrive. The blend factor is written through the APB-style port at byte
// address 0 and should be changed only while the pipeline is empty, since
// items in flight read it in their product stage.
module warp_point_lerp_bilinear_weights (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [wplbw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [wplbw_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [wplbw_pkg::APB_DATA_W-1:0] prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  src_tran_x,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  src_tran_y,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  dst_tran_x,
    input  wire logic signed [wplbw_pkg::COORD_W-1:0]  dst_tran_y,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [wplbw_pkg::SCREEN_BITS-1:0]     screen_x,
    output logic      [wplbw_pkg::SCREEN_BITS-1:0]     screen_y,
    output logic                                       x_off_screen,
    output logic                                       y_off_screen,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_top_left,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_top_right,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_bottom_left,
    output logic      [wplbw_pkg::WEIGHT_W-1:0]        weight_bottom_right
);

    logic [wplbw_pkg::FACTOR_W-1:0]      blend_factor;
    logic signed [wplbw_pkg::SUM_W-1:0]  bx, by;
    wplbw_pkg::stage_en_t                en;

    // Valid bits that travel with the items through the four stages.
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb
    begin
        en.s4 = !v4_reg || out_ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign in_ready  = en.s1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    wplbw_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .blend_factor (blend_factor)
    );

    // One blend unit for each axis; both see the same stage enables.
    wplbw_blend u_blend_x (
        .clk          (clk),
        .en           (en),
        .blend_factor (blend_factor),
        .src          (src_tran_x),
        .dst          (dst_tran_x),
        .blended      (bx)
    );

    wplbw_blend u_blend_y (
        .clk          (clk),
        .en           (en),
        .blend_factor (blend_factor),
        .src          (src_tran_y),
        .dst          (dst_tran_y),
        .blended      (by)
    );

    wplbw_split u_split (
        .clk                 (clk),
        .en                  (en),
        .bx                  (bx),
        .by                  (by),
        .screen_x            (screen_x),
        .screen_y            (screen_y),
        .x_off_screen        (x_off_screen),
        .y_off_screen        (y_off_screen),
        .weight_top_left     (weight_top_left),
        .weight_top_right    (weight_top_right),
        .weight_bottom_left  (weight_bottom_left),
        .weight_bottom_right (weight_bottom_right)
    );

endmodule
`default_nettype wire
